// ===== rtl/middle_insert_queue_macros.svh =====
// ----------------------------------------------------------------------------
// middle_insert_queue assertion macros
// Shared concurrent assertion forms for the queue RTL. Both sample on clk_i
// and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MIDDLE_INSERT_QUEUE_MACROS_SVH
`define MIDDLE_INSERT_QUEUE_MACROS_SVH

// Same-cycle implication
`define MIQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/miq_pkg.sv =====
// ----------------------------------------------------------------------------
// miq_pkg
// Shared constants, codes and beat types of the middle-insert queue.
// ----------------------------------------------------------------------------
package miq_pkg;

  // Queue sizing; the queue is kept as a front half and a back half
  localparam int CAPACITY   = 1024;
  localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
  localparam int PTR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // Action codes on the input stream
  localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd2;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_INSERT,
    CMD_NOP
  } cmd_kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Front-to-back command
  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    status_e                   status;
    logic [COUNT_W-1:0]        count;
  } res_t;

endpackage

// ===== rtl/middle_insert_queue.sv =====
// ----------------------------------------------------------------------------
// middle_insert_queue
// Each request beat passes the front command queue and the result register;
// a pop that removes an entry and a push onto a non-empty even count also
// pass the move state for a registered half-queue read, and the back end
// takes no further request until it ends. Throughput: one request per cycle
// otherwise, while the result stream is not stalled.
// Reset: count and all half-queue pointers clear at once; no clearing pass.
// ----------------------------------------------------------------------------
module middle_insert_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] popped_value, [42:32] count, rest zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  logic          cmd_valid, cmd_ready;
  miq_pkg::cmd_t cmd;
  miq_pkg::res_t res;

  miq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (s_axis_tuser_i),
    .in_value_i  (s_axis_tdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  miq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // pack result beat
  assign m_axis_tdata_o = {5'd0, res.count, res.popped_value};
  assign m_axis_tuser_o = res.status;

endmodule

// ===== rtl/miq_front.sv =====
// ----------------------------------------------------------------------------
// miq_front
// Accepts request beats, classifies the action code and holds the commands
// in a two-entry queue ahead of the back end.
// ----------------------------------------------------------------------------
module miq_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request side
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [miq_pkg::ACTION_W-1:0]        in_action_i,
  input  logic signed [miq_pkg::VALUE_W-1:0]  in_value_i,
  // command side
  output logic                                cmd_valid_o,
  input  logic                                cmd_ready_i,
  output miq_pkg::cmd_t                       cmd_o
);

  localparam int QDEPTH = 2;

  miq_pkg::cmd_t    fifo_q [QDEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             push, pop;
  miq_pkg::cmd_t    cmd_in;

  // classify the action
  always_comb begin
    cmd_in.value = in_value_i;
    unique case (in_action_i)
      miq_pkg::ACT_PUSH:   cmd_in.kind = miq_pkg::CMD_PUSH;
      miq_pkg::ACT_POP:    cmd_in.kind = miq_pkg::CMD_POP;
      miq_pkg::ACT_INSERT: cmd_in.kind = miq_pkg::CMD_INSERT;
      default:             cmd_in.kind = miq_pkg::CMD_NOP;
    endcase
  end

  assign in_ready_o  = (fill_q != 2'(QDEPTH));
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  // queue pointers
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/miq_back.sv =====
// ----------------------------------------------------------------------------
// miq_back
// Executes queue commands on two circular half-queues: the front half holds
// the first ceil(n/2) entries, the back half the rest. Insert-middle lands
// at the seam; one head-of-back to tail-of-front move keeps the halves even.
// ----------------------------------------------------------------------------
`include "middle_insert_queue_macros.svh"

module miq_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command side
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  miq_pkg::cmd_t        cmd_i,
  // result side
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output miq_pkg::res_t        res_o
);

  localparam int PTR_W = miq_pkg::PTR_W;
  localparam int CNT_W = miq_pkg::COUNT_W;
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(miq_pkg::CAPACITY);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(miq_pkg::HALF_DEPTH - 1);

  typedef enum logic {
    S_IDLE,
    S_MOVE
  } state_e;

  // circular pointer helpers
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  // half-queue memories
  logic [miq_pkg::VALUE_W-1:0] front_mem [miq_pkg::HALF_DEPTH];
  logic [miq_pkg::VALUE_W-1:0] back_mem  [miq_pkg::HALF_DEPTH];
  logic [miq_pkg::VALUE_W-1:0] f_rdata_q, b_rdata_q;

  // control state
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [PTR_W-1:0]    f_head_q, f_head_d, f_tail_q, f_tail_d;
  logic [PTR_W-1:0]    b_head_q, b_head_d, b_tail_q, b_tail_d;
  logic [PTR_W-1:0]    mv_addr_q, mv_addr_d;
  logic                mv_q, mv_d;
  logic                pop_q, pop_d;
  logic                out_valid_q, out_valid_d;
  miq_pkg::res_t       out_q, out_d;

  // write ports
  logic                         f_we, b_we;
  logic [PTR_W-1:0]             f_waddr, b_waddr;
  logic [miq_pkg::VALUE_W-1:0]  f_wdata, b_wdata;

  logic take, is_even, is_full, is_empty, is_store, load;
  miq_pkg::status_e st;

  assign cmd_ready_o = (state_q == S_IDLE) && (!out_valid_q || res_ready_i);
  assign take        = cmd_ready_o && cmd_valid_i;
  assign is_even     = ~count_q[0];
  assign is_full     = (count_q >= CAP_CNT);
  assign is_empty    = (count_q == '0);
  assign is_store    = (cmd_i.kind == miq_pkg::CMD_PUSH) || (cmd_i.kind == miq_pkg::CMD_INSERT);

  // command sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    f_head_d  = f_head_q;
    f_tail_d  = f_tail_q;
    b_head_d  = b_head_q;
    b_tail_d  = b_tail_q;
    mv_addr_d = mv_addr_q;
    mv_d      = mv_q;
    pop_d     = pop_q;
    f_we      = 1'b0;
    f_waddr   = f_tail_q;
    f_wdata   = cmd_i.value;
    b_we      = 1'b0;
    b_waddr   = b_tail_q;
    b_wdata   = cmd_i.value;
    st        = miq_pkg::ST_OK;
    load      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          mv_d  = 1'b0;
          pop_d = 1'b0;
          unique case (cmd_i.kind)
            miq_pkg::CMD_PUSH: begin
              if (is_full) begin
                st   = miq_pkg::ST_FULL;
                load = 1'b1;
              end else if (is_empty) begin
                // first entry goes straight to the front half
                f_we     = 1'b1;
                f_tail_d = ptr_inc(f_tail_q);
                count_d  = count_q + 1'b1;
                load     = 1'b1;
              end else if (is_even) begin
                // front half grows: move back head over, append to back
                b_we      = 1'b1;
                b_tail_d  = ptr_inc(b_tail_q);
                b_head_d  = ptr_inc(b_head_q);
                mv_addr_d = f_tail_q;
                f_tail_d  = ptr_inc(f_tail_q);
                mv_d      = 1'b1;
                count_d   = count_q + 1'b1;
                state_d   = S_MOVE;
              end else begin
                b_we     = 1'b1;
                b_tail_d = ptr_inc(b_tail_q);
                count_d  = count_q + 1'b1;
                load     = 1'b1;
              end
            end
            miq_pkg::CMD_INSERT: begin
              if (is_full) begin
                st   = miq_pkg::ST_FULL;
                load = 1'b1;
              end else if (is_even) begin
                // new value closes the front half
                f_we     = 1'b1;
                f_tail_d = ptr_inc(f_tail_q);
                count_d  = count_q + 1'b1;
                load     = 1'b1;
              end else begin
                // new value opens the back half
                b_we     = 1'b1;
                b_waddr  = ptr_dec(b_head_q);
                b_head_d = ptr_dec(b_head_q);
                count_d  = count_q + 1'b1;
                load     = 1'b1;
              end
            end
            miq_pkg::CMD_POP: begin
              if (is_empty) begin
                st   = miq_pkg::ST_EMPTY;
                load = 1'b1;
              end else begin
                pop_d    = 1'b1;
                f_head_d = ptr_inc(f_head_q);
                count_d  = count_q - 1'b1;
                if (is_even) begin
                  // front half shrinks too far: refill from back head
                  b_head_d  = ptr_inc(b_head_q);
                  mv_addr_d = f_tail_q;
                  f_tail_d  = ptr_inc(f_tail_q);
                  mv_d      = 1'b1;
                end
                state_d = S_MOVE;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_MOVE: begin
        f_we    = mv_q;
        f_waddr = mv_addr_q;
        f_wdata = b_rdata_q;
        load    = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    if (load) begin
      out_valid_d        = 1'b1;
      out_d.popped_value = pop_d && (state_q == S_MOVE) ? f_rdata_q : '0;
      out_d.status       = st;
      out_d.count        = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      f_head_q    <= '0;
      f_tail_q    <= '0;
      b_head_q    <= '0;
      b_tail_q    <= '0;
      mv_addr_q   <= '0;
      mv_q        <= 1'b0;
      pop_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      f_head_q    <= f_head_d;
      f_tail_q    <= f_tail_d;
      b_head_q    <= b_head_d;
      b_tail_q    <= b_tail_d;
      mv_addr_q   <= mv_addr_d;
      mv_q        <= mv_d;
      pop_q       <= pop_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // memories: one write and one registered head read each
  always_ff @(posedge clk_i) begin
    if (f_we) begin
      front_mem[f_waddr] <= f_wdata;
    end
    f_rdata_q <= front_mem[f_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      back_mem[b_waddr] <= b_wdata;
    end
    b_rdata_q <= back_mem[b_head_q];
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // checks
  `MIQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_CNT, "count above capacity")
  `MIQ_ASSERT_NEXT(a_move_one_cycle, state_q == S_MOVE, state_q == S_IDLE, "move stuck")
  `MIQ_ASSERT_NOW(a_move_slot_free, state_q == S_MOVE, !out_valid_q, "result slot busy in move")
  `MIQ_ASSERT_NEXT(a_full_drop, take && is_full && is_store, $stable(count_q), "drop changed count")

endmodule
